/* sv/mbi_pkg.sv */
// Shared types and constants for the MurmurHash2 bucket index block.
// No dependencies; every other file of the block imports this package.
package mbi_pkg;

    // Multiplier and shift amounts of 32-bit MurmurHash2.
    localparam logic [31:0] MIX_MULT    = 32'h5bd1_e995;
    localparam int          WORD_SHIFT  = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;

    // Register reset values.
    localparam logic [31:0] TABLE_SIZE_RESET = 32'd255;
    localparam logic [31:0] SEED_RESET       = 32'd0;

    // Configuration register indexes.
    localparam logic CFG_SEED       = 1'b0;
    localparam logic CFG_TABLE_SIZE = 1'b1;

    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Width of the divider step counter.
    localparam int DIV_CNT_W = 5;

    // How an item changes the accumulator.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_WORD,
        OP_TAIL
    } mix_op_t;

    // One classified item as it waits in the queue.
    typedef struct packed {
        mix_op_t     op;
        logic [31:0] word;
        logic [31:0] init;
        logic        first;
        logic        last;
    } item_t;

    // Sequencer states of the back part.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WORD1,
        ST_WORD2,
        ST_WORD3,
        ST_TAIL,
        ST_FIN,
        ST_DSTART,
        ST_DIV
    } back_state_t;

    // Handshake between the back part and the divider.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

endpackage

/* sv/mbi_front.sv */
// Front part: accepts key beats and classifies them into queue entries.
// Depends on mbi_pkg.
module mbi_front (
    input  logic                 key_valid,
    output logic                 key_stall,
    input  logic [31:0]          key_word,
    input  logic [2:0]           byte_count,
    input  logic [31:0]          key_length,
    input  logic                 first_item,
    input  logic                 last_item,
    input  logic [31:0]          seed_value,
    input  logic                 queue_full,
    output logic                 push,
    output mbi_pkg::item_t       push_item
);
    import mbi_pkg::*;

    logic [31:0] tail_mask;
    mix_op_t     op;

    // Decode the byte count into an operation and a mask for the tail bytes.
    always_comb
    begin
        case (byte_count)
            3'd0:
            begin
                op        = OP_NONE;
                tail_mask = 32'h0000_0000;
            end
            3'd1:
            begin
                op        = OP_TAIL;
                tail_mask = 32'h0000_00ff;
            end
            3'd2:
            begin
                op        = OP_TAIL;
                tail_mask = 32'h0000_ffff;
            end
            3'd3:
            begin
                op        = OP_TAIL;
                tail_mask = 32'h00ff_ffff;
            end
            default:
            begin
                op        = OP_WORD;
                tail_mask = 32'hffff_ffff;
            end
        endcase
    end

    // Build the queue entry; the start value is worked out here once.
    always_comb
    begin
        push_item.op    = op;
        push_item.word  = key_word & tail_mask;
        push_item.init  = seed_value ^ key_length;
        push_item.first = first_item;
        push_item.last  = last_item;
    end

    assign key_stall = queue_full;
    assign push      = key_valid & ~queue_full;

endmodule

/* sv/mbi_queue.sv */
// Short queue of classified items between the front and the back part.
// Depends on mbi_pkg.
module mbi_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mbi_pkg::item_t       push_item,
    output logic                 full,
    input  logic                 pop,
    output mbi_pkg::item_t       pop_item,
    output logic                 empty
);
    import mbi_pkg::*;

    item_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* sv/mbi_divider.sv */
// Iterative restoring divider that returns the remainder, one bit a cycle.
// Depends on mbi_pkg.
module mbi_divider (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mbi_pkg::div_req_t    req,
    output logic                 done,
    output logic [31:0]          remainder
);
    import mbi_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [31:0]          rem_reg;
    logic [31:0]          rem_next;
    logic [31:0]          dq_reg;
    logic [31:0]          dq_next;
    logic [31:0]          divisor_reg;
    logic [31:0]          divisor_next;
    logic                 zero_reg;
    logic                 zero_next;
    logic [32:0]          trial;
    logic [32:0]          diff;

    // One restoring step: shift in the next dividend bit and subtract if it fits.
    assign trial = {rem_reg, dq_reg[31]};
    assign diff  = trial - {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        divisor_next = divisor_reg;
        zero_next    = zero_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            rem_next     = '0;
            dq_next      = req.dividend;
            divisor_next = req.divisor;
            zero_next    = (req.divisor == '0);
        end
        else if (busy_reg)
        begin
            rem_next = diff[32] ? trial[31:0] : diff[31:0];
            dq_next  = {dq_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        divisor_reg <= divisor_next;
        zero_reg    <= zero_next;
    end

    // A table size of zero gives bucket zero.
    assign done      = done_reg;
    assign remainder = zero_reg ? 32'd0 : rem_reg;

endmodule

/* sv/mbi_back.sv */
// Back part: mixes queued items into the accumulator with one shared
// multiplier, finalises the hash and drives the result beat. Depends on mbi_pkg.
module mbi_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 queue_empty,
    input  mbi_pkg::item_t       pop_item,
    output logic                 pop,
    input  logic [31:0]          table_size,
    output mbi_pkg::div_req_t    div_req,
    input  logic                 div_done,
    input  logic [31:0]          div_remainder,
    output logic                 bucket_valid,
    input  logic                 bucket_stall,
    output logic [31:0]          bucket_idx
);
    import mbi_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [31:0] w_reg;
    logic [31:0] w_next;
    logic        last_reg;
    logic        last_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_reg;
    logic [31:0] out_next;
    logic [31:0] mult_a;
    logic [31:0] prod;
    logic [31:0] acc_start;

    // The single multiplier; its operand is chosen by the sequencer state.
    assign prod = mult_a * MIX_MULT;

    assign acc_start = pop_item.first ? pop_item.init : acc_reg;

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        w_next         = w_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        mult_a         = acc_reg;
        pop            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = w_reg ^ (w_reg >> FIN_SHIFT_B);
        div_req.divisor  = table_size;

        // The result beat leaves when the receiver is not stalling.
        if (out_valid_reg && !bucket_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop       = 1'b1;
                    acc_next  = acc_start;
                    w_next    = pop_item.word;
                    last_next = pop_item.last;
                    case (pop_item.op)
                        OP_WORD: state_next = ST_WORD1;
                        OP_TAIL: state_next = ST_TAIL;
                        default: state_next = pop_item.last ? ST_FIN : ST_IDLE;
                    endcase
                end
            end
            ST_WORD1:
            begin
                mult_a     = w_reg;
                w_next     = prod;
                state_next = ST_WORD2;
            end
            ST_WORD2:
            begin
                mult_a     = w_reg ^ (w_reg >> WORD_SHIFT);
                w_next     = prod;
                state_next = ST_WORD3;
            end
            ST_WORD3:
            begin
                mult_a     = acc_reg;
                acc_next   = prod ^ w_reg;
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_TAIL:
            begin
                mult_a     = acc_reg ^ w_reg;
                acc_next   = prod;
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                // The finalised hash is built in w_reg; the accumulator keeps its value.
                mult_a     = acc_reg ^ (acc_reg >> FIN_SHIFT_A);
                w_next     = prod;
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                // Start the divider only once the output register is free or emptying.
                if (!out_valid_reg || !bucket_stall)
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    out_valid_next = 1'b1;
                    out_next       = div_remainder;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

    assign bucket_valid = out_valid_reg;
    assign bucket_idx   = out_reg;

endmodule

/* sv/murmur2_bucket_index_core.sv */
// Top level of the MurmurHash2 bucket index block: configuration registers,
// front part, queue, back part and divider. Depends on mbi_pkg and its submodules.
//
// Hashes a key with 32-bit MurmurHash2 and returns the hash modulo table_size.
// Key beats carry up to four little-endian bytes; the first beat loads the
// accumulator with the seed XOR key_length, and the last beat produces one
// bucket_idx beat. Beats are classified and queued (two entries) so the key
// side keeps moving while the back part works. The back part uses one 32-bit
// multiplier: its idle state takes a beat from the queue, then it runs three
// states for a full word, one for a tail of one to three bytes, none for an empty
// beat. A last beat adds a finalising state, a divider start state and the 32
// steps of the bit-serial divider, whose remainder is handed over registered.
// The result is held in an output register until taken while the back part goes
// on with the next key; only the next divider start waits for that register.
// Write the seed and table_size only while no key is in flight; a table size of
// zero gives bucket zero.
module murmur2_bucket_index_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_valid,
    output logic        key_stall,
    input  logic [31:0] key_word,
    input  logic [2:0]  byte_count,
    input  logic [31:0] key_length,
    input  logic        first_item,
    input  logic        last_item,
    output logic        bucket_valid,
    input  logic        bucket_stall,
    output logic [31:0] bucket_idx,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import mbi_pkg::*;

    logic [31:0] seed_reg;
    logic [31:0] table_size_reg;
    logic        queue_full;
    logic        queue_empty;
    logic        push;
    logic        pop;
    item_t       push_item;
    item_t       pop_item;
    div_req_t    div_req;
    logic        div_done;
    logic [31:0] div_remainder;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg       <= SEED_RESET;
            table_size_reg <= TABLE_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEED:       seed_reg       <= cfg_data;
                CFG_TABLE_SIZE: table_size_reg <= cfg_data;
                default:        seed_reg       <= seed_reg;
            endcase
        end
    end

    mbi_front u_front (
        .key_valid  (key_valid),
        .key_stall  (key_stall),
        .key_word   (key_word),
        .byte_count (byte_count),
        .key_length (key_length),
        .first_item (first_item),
        .last_item  (last_item),
        .seed_value (seed_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    mbi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    mbi_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_empty   (queue_empty),
        .pop_item      (pop_item),
        .pop           (pop),
        .table_size    (table_size_reg),
        .div_req       (div_req),
        .div_done      (div_done),
        .div_remainder (div_remainder),
        .bucket_valid  (bucket_valid),
        .bucket_stall  (bucket_stall),
        .bucket_idx    (bucket_idx)
    );

    mbi_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .done      (div_done),
        .remainder (div_remainder)
    );

endmodule

/* tb/sv/murmur2_bucket_index_core_test.sv */
// Self-checking testbench for murmur2_bucket_index_core: directed key beats from a
// table, then random keys, each result checked against a MurmurHash2 predictor.
// Depends on mbi_pkg and the RTL of the block only.
module murmur2_bucket_index_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mbi_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500_000;
    localparam int unsigned QUIET_CYCLES = 64;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned BEATS_PER_SETTING = 167;

    // One key beat as presented on the key channel.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  count;
        logic [31:0] length;
        logic        first;
        logic        last;
    } key_beat_t;

    // Kinds of row in the directed table.
    typedef enum logic [1:0] {
        ROW_KEY,
        ROW_SEED,
        ROW_SIZE
    } row_kind_t;

    // A directed row: a key beat, or a register write with its value in word.
    // Where pinned is set, the expected bucket is the one typed in the row.
    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] word;
        logic [2:0]  count;
        logic [31:0] length;
        logic        first;
        logic        last;
        logic        pinned;
        logic [31:0] pinned_idx;
    } dir_row_t;

    localparam int DIR_ROWS = 27;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // Missing first beat straight after reset: accumulator is zero.
        '{ROW_KEY,  32'h0000_0000, 3'd0, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'd0},
        // Empty key with seed and length both zero.
        '{ROW_KEY,  32'h0000_0000, 3'd0, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 32'd0},
        '{ROW_KEY,  32'hFFFF_FFFF, 3'd4, 32'h0000_0004, 1'b1, 1'b1, 1'b0, 32'd0},
        // Tails of one, two and three bytes with the unused bits set.
        '{ROW_KEY,  32'hFFFF_FF80, 3'd1, 32'h0000_0001, 1'b1, 1'b1, 1'b0, 32'd0},
        '{ROW_KEY,  32'hA5A5_FFFF, 3'd2, 32'h0000_0002, 1'b1, 1'b1, 1'b0, 32'd0},
        '{ROW_KEY,  32'h8000_7F01, 3'd3, 32'h0000_0003, 1'b1, 1'b1, 1'b0, 32'd0},
        // Two-beat key: full word then one tail byte.
        '{ROW_KEY,  32'h0000_0000, 3'd4, 32'h0000_0005, 1'b1, 1'b0, 1'b0, 32'd0},
        '{ROW_KEY,  32'hFFFF_FFAB, 3'd1, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 32'd0},
        // Byte counts above four count as a full word.
        '{ROW_KEY,  32'h1234_5678, 3'd7, 32'h0000_0004, 1'b1, 1'b1, 1'b0, 32'd0},
        '{ROW_KEY,  32'h8765_4321, 3'd5, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'd0},
        '{ROW_KEY,  32'hDEAD_BEEF, 3'd6, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'd0},
        // Last beat carrying no bytes.
        '{ROW_KEY,  32'hCAFE_F00D, 3'd0, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 32'd0},
        // Partial word before the last beat.
        '{ROW_KEY,  32'h0102_0304, 3'd2, 32'h0000_0006, 1'b1, 1'b0, 1'b0, 32'd0},
        '{ROW_KEY,  32'h0506_0708, 3'd4, 32'h0000_0006, 1'b0, 1'b1, 1'b0, 32'd0},
        // Key without a first beat carries on from the previous accumulator.
        '{ROW_KEY,  32'h1234_5678, 3'd4, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 32'd0},
        // Seed all ones with length all ones cancels to a zero hash.
        '{ROW_SEED, 32'hFFFF_FFFF, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_KEY,  32'h0000_0000, 3'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'd0},
        // A zero table size and a single bucket both give bucket zero.
        '{ROW_SIZE, 32'h0000_0000, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_KEY,  32'h5555_5555, 3'd4, 32'h0000_0004, 1'b1, 1'b1, 1'b1, 32'd0},
        '{ROW_SIZE, 32'h0000_0001, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_KEY,  32'hAAAA_AAAA, 3'd3, 32'h0000_0003, 1'b1, 1'b1, 1'b1, 32'd0},
        '{ROW_SIZE, 32'hFFFF_FFFF, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_KEY,  32'h7FFF_FFFF, 3'd4, 32'h0000_0004, 1'b1, 1'b1, 1'b0, 32'd0},
        '{ROW_SEED, 32'h5BD1_E995, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_SIZE, 32'd1000,      3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_KEY,  32'hC3C3_C3C3, 3'd4, 32'h0000_0008, 1'b1, 1'b0, 1'b0, 32'd0},
        '{ROW_KEY,  32'h3C3C_3C3C, 3'd4, 32'h0000_0008, 1'b0, 1'b1, 1'b0, 32'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        key_valid = 1'b0;
    logic        key_stall;
    logic [31:0] key_word = '0;
    logic [2:0]  byte_count = '0;
    logic [31:0] key_length = '0;
    logic        first_item = 1'b0;
    logic        last_item = 1'b0;
    logic        bucket_valid;
    logic        bucket_stall = 1'b0;
    logic [31:0] bucket_idx;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_SEED;
    logic [31:0] cfg_data = '0;

    // Predictor state: register copies and the running accumulator.
    logic [31:0] seed_copy = SEED_RESET;
    logic [31:0] size_copy = TABLE_SIZE_RESET;
    logic [31:0] acc_copy = '0;

    logic [31:0] buckets_due [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 32;
    int unsigned recv_idle_pct = 45;

    // Long receiver hold-off, requested by the stimulus and counted by the receiver.
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    murmur2_bucket_index_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_stall    (key_stall),
        .key_word     (key_word),
        .byte_count   (byte_count),
        .key_length   (key_length),
        .first_item   (first_item),
        .last_item    (last_item),
        .bucket_valid (bucket_valid),
        .bucket_stall (bucket_stall),
        .bucket_idx   (bucket_idx),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // Full four-byte word: multiply, shift and multiply, then fold into the hash.
    function automatic logic [31:0] mix_full_word(input logic [31:0] acc,
                                                  input logic [31:0] w);
        logic [31:0] k;
        k = w * MIX_MULT;
        k = k ^ (k >> WORD_SHIFT);
        k = k * MIX_MULT;
        acc = acc * MIX_MULT;
        return acc ^ k;
    endfunction

    // Tail of one to three bytes: fold in the low bytes, then multiply.
    function automatic logic [31:0] mix_tail_bytes(input logic [31:0] acc,
                                                   input logic [31:0] w,
                                                   input logic [2:0] n);
        logic [31:0] mask;
        mask = (n == 3'd1) ? 32'h0000_00FF : (n == 3'd2) ? 32'h0000_FFFF : 32'h00FF_FFFF;
        acc = acc ^ (w & mask);
        return acc * MIX_MULT;
    endfunction

    function automatic logic [31:0] finalise_hash(input logic [31:0] h);
        h = h ^ (h >> FIN_SHIFT_A);
        h = h * MIX_MULT;
        h = h ^ (h >> FIN_SHIFT_B);
        return h;
    endfunction

    // Advances the accumulator by one accepted beat; returns 1 with the bucket
    // when the beat closes a key.
    function automatic bit absorb_beat(input key_beat_t b, output logic [31:0] bucket);
        logic [31:0] h;
        bucket = '0;
        if (b.first)
            acc_copy = seed_copy ^ b.length;
        if (b.count >= 3'd4)
            acc_copy = mix_full_word(acc_copy, b.word);
        else if (b.count != 3'd0)
            acc_copy = mix_tail_bytes(acc_copy, b.word, b.count);
        if (!b.last)
            return 1'b0;
        h = finalise_hash(acc_copy);
        bucket = (size_copy != 0) ? h % size_copy : 32'd0;
        return 1'b1;
    endfunction

    // Offers one beat, idling first at random, and records its bucket on acceptance.
    task automatic send_beat(input key_beat_t b, input logic pinned,
                             input logic [31:0] pinned_idx);
        logic [31:0] bucket;
        if ($urandom_range(99) < send_idle_pct)
        begin
            key_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        key_valid  <= 1'b1;
        key_word   <= b.word;
        byte_count <= b.count;
        key_length <= b.length;
        first_item <= b.first;
        last_item  <= b.last;
        @(posedge clk);
        while (key_stall !== 1'b0)
            @(posedge clk);
        if (absorb_beat(b, bucket))
            buckets_due.push_back(pinned ? pinned_idx : bucket);
    endtask

    // Lets every outstanding result arrive and the back part drain.
    task automatic wait_quiet();
        key_valid <= 1'b0;
        while (buckets_due.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SEED)
            seed_copy = val;
        else
            size_copy = val;
        @(posedge clk);
    endtask

    // Random keys, mostly well formed, with some truncated keys and loose beats.
    task automatic run_random(input int unsigned n_beats_wanted);
        int unsigned sent;
        int unsigned key_len;
        int unsigned n_full;
        int unsigned n_beats;
        int unsigned n_send;
        logic [2:0]  tail;
        logic [31:0] claimed;
        key_beat_t   b;
        sent = 0;
        while (sent < n_beats_wanted)
        begin
            if ($urandom_range(99) < 12)
            begin
                b.word   = $urandom;
                b.count  = 3'($urandom_range(7));
                b.length = $urandom;
                b.first  = 1'($urandom_range(1));
                b.last   = 1'($urandom_range(1));
                send_beat(b, 1'b0, '0);
                sent++;
            end
            else
            begin
                key_len = ($urandom_range(9) < 7) ? $urandom_range(12) : $urandom_range(64, 13);
                claimed = ($urandom_range(19) == 0) ? $urandom : key_len;
                n_full  = key_len / 4;
                tail    = 3'(key_len % 4);
                n_beats = n_full + ((tail != 0) ? 1 : 0);
                if (n_beats == 0)
                    n_beats = 1;
                n_send = n_beats;
                if (n_beats > 1 && $urandom_range(9) == 0)
                    n_send = $urandom_range(n_beats - 1, 1);
                for (int i = 0; i < n_send; i++)
                begin
                    b.word   = $urandom;
                    b.count  = (i < n_full) ? 3'd4 : tail;
                    b.length = (i == 0) ? claimed : $urandom;
                    b.first  = (i == 0);
                    b.last   = (i == n_beats - 1);
                    send_beat(b, 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // Receiver: random stalls, or a long hold-off once requested.
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen    <= hold_req;
            hold_left    <= HOLD_CYCLES;
            bucket_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            bucket_stall <= 1'b1;
        end
        else
            bucket_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Each accepted result beat is compared with the oldest bucket due.
    always @(posedge clk)
    begin
        if (rst_n && bucket_valid === 1'b1 && bucket_stall === 1'b0)
        begin
            if (buckets_due.size() == 0)
            begin
                $error("bucket_idx: no result expected, got %0h", bucket_idx);
                mismatch_count++;
            end
            else if (bucket_idx !== buckets_due[0])
            begin
                $error("bucket_idx: expected %0h, got %0h", buckets_due[0], bucket_idx);
                mismatch_count++;
                void'(buckets_due.pop_front());
            end
            else
                void'(buckets_due.pop_front());
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] seed_val;
        logic [31:0] size_val;
        key_beat_t   b;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: register writes wait for the block to go quiet.
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].kind == ROW_KEY)
            begin
                b.word   = dir_rows[r].word;
                b.count  = dir_rows[r].count;
                b.length = dir_rows[r].length;
                b.first  = dir_rows[r].first;
                b.last   = dir_rows[r].last;
                send_beat(b, dir_rows[r].pinned, dir_rows[r].pinned_idx);
            end
            else
            begin
                wait_quiet();
                write_reg((dir_rows[r].kind == ROW_SEED) ? CFG_SEED : CFG_TABLE_SIZE,
                          dir_rows[r].word);
            end
        end

        // Random part: three idling patterns, two register settings each.
        for (int k = 0; k < 6; k++)
        begin
            case (k / 2)
                0:
                begin
                    send_idle_pct = 32;
                    recv_idle_pct = 45;
                end
                1:
                begin
                    send_idle_pct = 45;
                    recv_idle_pct = 32;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            seed_val = $urandom;
            case (k)
                0: size_val = $urandom_range(64, 1);
                1:
                begin
                    seed_val = 32'hFFFF_FFFF;
                    size_val = 32'hFFFF_FFFF;
                end
                2: size_val = $urandom;
                3:
                begin
                    seed_val = 32'h0000_0000;
                    size_val = $urandom_range(300, 2);
                end
                4: size_val = 32'h8000_0000;
                default: size_val = $urandom;
            endcase
            wait_quiet();
            write_reg(CFG_SEED, seed_val);
            write_reg(CFG_TABLE_SIZE, size_val);
            // With no idling, hold the receiver off so the block backs up.
            if (k == 4)
                hold_req <= hold_req + 1;
            run_random(BEATS_PER_SETTING);
        end

        key_valid <= 1'b0;
        while (buckets_due.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && buckets_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
